>>> hdl/osm_pkg.sv
// Package with shared constants for the order statistic multiset block.
`default_nettype none
package osm_pkg;

    // Default number of stored keys.
    localparam int CAPACITY_DEF = 1024;
    // Default key width in bits.
    localparam int KEY_BITS_DEF = 31;
    // The rank field of a command word is fixed at ten bits.
    localparam int RANK_BITS = 10;

endpackage
`default_nettype wire

>>> hdl/osm_key_ram.sv
// Simple dual-port key memory with one write port and one registered read port.
`default_nettype none
module osm_key_ram #(
    parameter int DEPTH = osm_pkg::CAPACITY_DEF,
    parameter int WIDTH = osm_pkg::KEY_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/order_statistic_multiset_top.sv
// Top level of the order statistic multiset: sequencer, shared key comparator and key memory.
//
// Channel   Direction  Handshake                Payload
// command   in         start high, busy low     i_operation, i_key, i_rank
// result    out        o_valid for one cycle    o_selected_key, o_set_empty, o_insert_dropped
//
// Keys are kept in ascending order in a single-port-read memory; every scan step of an insert
// or erase reads one entry and compares it with the command key in the one shared comparator.
// An insert moves each stored key greater than the new key up by one entry, an erase scans the
// keys below it and then moves the keys above it down by one entry, and every command ends with
// a select that reads the entry at the rank, or the top entry when the rank is past the count.
// Reset clears the key count and the sequencer; the memory contents are not cleared.
// busy stays high from the accepted command until its result strobe; results cannot be stalled.
`default_nettype none
module order_statistic_multiset_top #(
    parameter int CAPACITY = osm_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = osm_pkg::KEY_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_operation,
    input  wire logic [KEY_BITS-1:0]           i_key,
    input  wire logic [osm_pkg::RANK_BITS-1:0] i_rank,
    output logic                               o_valid,
    output logic      [KEY_BITS-1:0]           o_selected_key,
    output logic                               o_set_empty,
    output logic                               o_insert_dropped
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = osm_pkg::RANK_BITS;
    localparam int MW = (RW > CW) ? RW : CW;

    localparam logic OP_INSERT = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_ERS_RD,
        S_ERS_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_SEL_RD,
        S_SEL_WAIT
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_pos, n_pos;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [RW-1:0]       r_rank, n_rank;
    logic                r_drop, n_drop;
    logic                r_valid, n_valid;
    logic [KEY_BITS-1:0] r_sel, n_sel;
    logic                r_empty, n_empty;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    logic                cmp_lt, cmp_eq, cmp_gt;
    logic [CW-1:0]       pos_m1, pos_p1, cnt_m1;
    logic [MW-1:0]       rank_x, count_x;
    logic [AW-1:0]       sel_addr;

    osm_key_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The one comparator every scan step shares: stored word against the command key.
    assign cmp_lt = ram_rdata < r_key;
    assign cmp_eq = ram_rdata == r_key;
    assign cmp_gt = !cmp_lt && !cmp_eq;

    assign pos_m1  = r_pos - CW'(1);
    assign pos_p1  = r_pos + CW'(1);
    assign cnt_m1  = r_count - CW'(1);
    assign rank_x  = MW'(r_rank);
    assign count_x = MW'(r_count);
    assign sel_addr = (rank_x < count_x) ? rank_x[AW-1:0] : cnt_m1[AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_rank    = r_rank;
        n_drop    = r_drop;
        n_valid   = 1'b0;
        n_sel     = r_sel;
        n_empty   = r_empty;
        ram_we    = 1'b0;
        ram_waddr = r_pos[AW-1:0];
        ram_wdata = r_key;
        ram_raddr = r_pos[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key  = i_key;
                    n_rank = i_rank;
                    n_drop = 1'b0;
                    if (i_operation == OP_INSERT) begin
                        n_pos = r_count;
                        if (r_count == CW'(CAPACITY)) begin
                            n_drop  = 1'b1;
                            n_state = S_SEL_RD;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end else begin
                        n_pos   = '0;
                        n_state = S_ERS_RD;
                    end
                end
            end
            // Insert walks down from the top, moving larger keys up by one entry.
            S_INS_RD: begin
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = S_SEL_RD;
                end else begin
                    ram_raddr = pos_m1[AW-1:0];
                    n_state   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = ram_rdata;
                    n_pos     = pos_m1;
                    n_state   = S_INS_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = S_SEL_RD;
                end
            end
            // Erase scans up for the first key not below the command key.
            S_ERS_RD: begin
                if (r_pos == r_count) begin
                    n_state = S_SEL_RD;
                end else begin
                    n_state = S_ERS_CMP;
                end
            end
            S_ERS_CMP: begin
                if (cmp_lt) begin
                    n_pos   = pos_p1;
                    n_state = S_ERS_RD;
                end else if (cmp_eq) begin
                    n_state = S_SHF_RD;
                end else begin
                    n_state = S_SEL_RD;
                end
            end
            S_SHF_RD: begin
                if (r_pos == cnt_m1) begin
                    n_count = cnt_m1;
                    n_state = S_SEL_RD;
                end else begin
                    ram_raddr = pos_p1[AW-1:0];
                    n_state   = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_pos     = pos_p1;
                n_state   = S_SHF_RD;
            end
            S_SEL_RD: begin
                if (r_count == '0) begin
                    n_sel   = '0;
                    n_empty = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_raddr = sel_addr;
                    n_state   = S_SEL_WAIT;
                end
            end
            S_SEL_WAIT: begin
                n_sel   = ram_rdata;
                n_empty = 1'b0;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_pos   <= n_pos;
        r_key   <= n_key;
        r_rank  <= n_rank;
        r_drop  <= n_drop;
        r_sel   <= n_sel;
        r_empty <= n_empty;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_selected_key   = r_sel;
    assign o_set_empty      = r_empty;
    assign o_insert_dropped = r_drop;

`ifndef SYNTH
    // The key count never goes past the memory depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("key count exceeds capacity");

    // An insert shift only runs when there is room for one more key.
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> (r_count < CW'(CAPACITY)))
        else $error("insert scan on a full store");

    // A dropped insert can only happen on a full store, which is never empty.
    a_drop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_insert_dropped && o_set_empty))
        else $error("dropped insert reported with an empty store");

    // An empty store reports a zero key.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_set_empty) |-> (o_selected_key == '0))
        else $error("empty result carries a nonzero key");

    // An accepted command word keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");
`endif

endmodule
`default_nettype wire

>>> test/tb_order_statistic_multiset_top.sv
// Self-checking testbench for the order statistic multiset block: random and directed commands.
`timescale 1ns / 1ps
module tb_order_statistic_multiset_top;

    localparam int KB = osm_pkg::KEY_BITS_DEF;
    localparam int CAPACITY = osm_pkg::CAPACITY_DEF;
    localparam int RB = osm_pkg::RANK_BITS;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int RANDOM_ITEMS = 700;

    typedef logic [KB-1:0] t_key;
    typedef logic [RB-1:0] t_rank;
    typedef enum logic {OP_INSERT = 1'b0, OP_ERASE = 1'b1} t_op;

    typedef struct packed {
        t_op   op;
        t_key  key;
        t_rank rank;
    } t_cmd;

    typedef struct packed {
        t_key selected;
        logic empty;
        logic dropped;
    } t_select;

    localparam t_key KEY_MAX = '1;
    localparam t_rank RANK_MAX = '1;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    logic  i_operation = 1'b0;
    t_key  i_key = '0;
    t_rank i_rank = '0;
    logic  o_valid;
    t_key  o_selected_key;
    logic  o_set_empty;
    logic  o_insert_dropped;

    t_cmd    cmd_backlog[$];
    t_select awaited_results[$];
    t_key    ordered_keys[$];
    t_key    live_keys[$];

    int n_issued = 0;
    int n_accepted = 0;
    int results_checked = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int hold_off = 0;
    int burst_left = 0;
    int peak_count = 0;
    int dropped_seen = 0;
    int empty_seen = 0;

    order_statistic_multiset_top #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KB)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_operation(i_operation),
        .i_key(i_key),
        .i_rank(i_rank),
        .o_valid(o_valid),
        .o_selected_key(o_selected_key),
        .o_set_empty(o_set_empty),
        .o_insert_dropped(o_insert_dropped)
    );

    always #10 i_clk = ~i_clk;

    // Updates the sorted copy with one command and returns the order statistic that follows.
    function automatic t_select update_and_select(t_cmd c);
        t_select r;
        int pos;
        r = '0;
        pos = 0;
        if (c.op == OP_INSERT) begin
            if (ordered_keys.size() >= CAPACITY) begin
                r.dropped = 1'b1;
            end else begin
                // A duplicate goes after the equal keys already stored.
                while (pos < ordered_keys.size() && ordered_keys[pos] <= c.key) pos++;
                ordered_keys.insert(pos, c.key);
            end
        end else begin
            while (pos < ordered_keys.size() && ordered_keys[pos] < c.key) pos++;
            if (pos < ordered_keys.size() && ordered_keys[pos] == c.key)
                ordered_keys.delete(pos);
        end
        if (ordered_keys.size() == 0)
            r.empty = 1'b1;
        else if (int'(c.rank) < ordered_keys.size())
            r.selected = ordered_keys[c.rank];
        else
            r.selected = ordered_keys[ordered_keys.size() - 1];
        return r;
    endfunction

    // Appends a command word and tracks which keys will be stored once it has run.
    task automatic queue_cmd(t_op op, t_key key, t_rank rank);
        t_cmd c;
        int idx;
        c.op = op;
        c.key = key;
        c.rank = rank;
        cmd_backlog.push_back(c);
        idx = 0;
        if (op == OP_INSERT) begin
            if (live_keys.size() < CAPACITY) live_keys.push_back(key);
        end else begin
            while (idx < live_keys.size() && live_keys[idx] != key) idx++;
            if (idx < live_keys.size()) live_keys.delete(idx);
        end
    endtask

    function automatic t_key pick_key();
        t_key k;
        int n;
        n = live_keys.size();
        k = t_key'($urandom());
        case ($urandom_range(0, 9))
            0, 1, 2: k = t_key'($urandom_range(0, 15));
            3: begin
                case ($urandom_range(0, 3))
                    0: k = '0;
                    1: k = KEY_MAX;
                    2: k = KEY_MAX - t_key'(1);
                    default: k = t_key'(1);
                endcase
            end
            4, 5: begin
                if (n > 0)
                    k = t_key'(live_keys[$urandom_range(0, n - 1)]
                               + t_key'($urandom_range(0, 2)) - t_key'(1));
            end
            default: ;
        endcase
        return k;
    endfunction

    function automatic t_rank pick_rank();
        int n;
        n = live_keys.size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_rank'($urandom_range(0, (n < CAPACITY) ? n : CAPACITY - 1));
            4: return $urandom_range(0, 1) ? RANK_MAX : '0;
            default: return t_rank'($urandom());
        endcase
    endfunction

    task automatic drain();
        while (cmd_backlog.size() != 0 || n_accepted != n_issued || awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Command driver: presents one word at a time and holds it until it is taken.
    always @(negedge i_clk) begin
        t_cmd w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (n_accepted == n_issued) begin
            if (hold_off > 0 || cmd_backlog.size() == 0) begin
                if (hold_off > 0) hold_off--;
                start <= 1'b0;
                i_operation <= 1'($urandom_range(0, 1));
                i_key <= t_key'($urandom());
                i_rank <= t_rank'($urandom());
            end else begin
                w = cmd_backlog.pop_front();
                start <= 1'b1;
                i_operation <= w.op;
                i_key <= w.key;
                i_rank <= w.rank;
                n_issued++;
                if (burst_left > 0) begin
                    burst_left--;
                    hold_off = 0;
                end else begin
                    hold_off = $urandom_range(0, 7);
                    if ($urandom_range(0, 31) == 0) burst_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // Result monitor: checks each strobed word against the oldest prediction.
    always @(posedge i_clk) begin
        t_select exp_word;
        t_cmd    taken;
        cycle_count++;
        if (i_rst_n) begin
            if (o_valid) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with no command outstanding");
                    fail_count++;
                end else begin
                    exp_word = awaited_results.pop_front();
                    results_checked++;
                    if (o_selected_key !== exp_word.selected) begin
                        $error("selected_key: expected %0d, actual %0d",
                               exp_word.selected, o_selected_key);
                        fail_count++;
                    end
                    if (o_set_empty !== exp_word.empty) begin
                        $error("set_empty: expected %0d, actual %0d", exp_word.empty, o_set_empty);
                        fail_count++;
                    end
                    if (o_insert_dropped !== exp_word.dropped) begin
                        $error("insert_dropped: expected %0d, actual %0d",
                               exp_word.dropped, o_insert_dropped);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                taken.op = t_op'(i_operation);
                taken.key = i_key;
                taken.rank = i_rank;
                exp_word = update_and_select(taken);
                awaited_results.push_back(exp_word);
                n_accepted++;
                if (ordered_keys.size() > peak_count) peak_count = ordered_keys.size();
                if (exp_word.dropped) dropped_seen++;
                if (exp_word.empty) empty_seen++;
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int n;
        t_key fill_key;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, extremes, duplicates, absent keys, rank at and past the count.
        queue_cmd(OP_ERASE, t_key'(5), '0);
        queue_cmd(OP_INSERT, '0, '0);
        queue_cmd(OP_INSERT, KEY_MAX, RANK_MAX);
        queue_cmd(OP_INSERT, '0, t_rank'(1));
        queue_cmd(OP_INSERT, KEY_MAX, t_rank'(3));
        queue_cmd(OP_INSERT, t_key'(32'h2AAA_AAAA), t_rank'(2));
        queue_cmd(OP_INSERT, t_key'(32'h5555_5555), t_rank'(10'h155));
        queue_cmd(OP_ERASE, t_key'(7), t_rank'(6));
        queue_cmd(OP_ERASE, '0, '0);
        queue_cmd(OP_ERASE, KEY_MAX, t_rank'(4));
        queue_cmd(OP_ERASE, KEY_MAX, RANK_MAX);
        queue_cmd(OP_ERASE, '0, t_rank'(10'h2AA));
        queue_cmd(OP_ERASE, t_key'(32'h2AAA_AAAA), '0);
        queue_cmd(OP_ERASE, t_key'(32'h5555_5555), RANK_MAX);
        queue_cmd(OP_ERASE, t_key'(32'h5555_5555), '0);
        queue_cmd(OP_INSERT, t_key'(1), t_rank'(10'h2AA));
        queue_cmd(OP_ERASE, t_key'(1), t_rank'(10'h155));
        drain();

        // Random: the store stays small so each command finishes quickly.
        repeat (RANDOM_ITEMS) begin
            n = live_keys.size();
            if (n == 0 || (n < 40 && $urandom_range(0, 99) < 55) || $urandom_range(0, 99) < 25)
                queue_cmd(OP_INSERT, pick_key(), pick_rank());
            else if ($urandom_range(0, 3) != 0)
                queue_cmd(OP_ERASE, live_keys[$urandom_range(0, n - 1)], pick_rank());
            else
                queue_cmd(OP_ERASE, pick_key(), pick_rank());
        end
        drain();

        // Fill to capacity with ascending keys, which keeps the shifting short.
        fill_key = t_key'($urandom_range(0, 32'h2000_0000));
        while (live_keys.size() < CAPACITY) begin
            fill_key = fill_key + t_key'($urandom_range(0, 3));
            queue_cmd(OP_INSERT, fill_key, t_rank'($urandom()));
        end
        drain();

        // A full store: inserts are dropped, erases and re-inserts still work.
        queue_cmd(OP_INSERT, pick_key(), RANK_MAX);
        queue_cmd(OP_INSERT, KEY_MAX, '0);
        queue_cmd(OP_INSERT, '0, t_rank'($urandom()));
        queue_cmd(OP_ERASE, KEY_MAX - t_key'(1), RANK_MAX);
        queue_cmd(OP_ERASE, live_keys[$urandom_range(0, CAPACITY - 1)], t_rank'($urandom()));
        queue_cmd(OP_INSERT, pick_key(), RANK_MAX);
        queue_cmd(OP_INSERT, pick_key(), t_rank'($urandom()));
        queue_cmd(OP_ERASE, live_keys[0], '0);
        queue_cmd(OP_INSERT, '0, '0);
        queue_cmd(OP_INSERT, '0, t_rank'(1));
        drain();

        repeat (2 * CAPACITY + 16) @(posedge i_clk);
        $display("Ran %0d command words and checked %0d result words; store peaked at %0d keys.",
                 n_accepted, results_checked, peak_count);
        $display("Dropped inserts predicted: %0d, empty-store results predicted: %0d.",
                 dropped_seen, empty_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
hdl/osm_pkg.sv
hdl/osm_key_ram.sv
hdl/order_statistic_multiset_top.sv
test/tb_order_statistic_multiset_top.sv
